// File: rtl/adts_fs_pkg.sv
package adts_fs_pkg;

    // Header geometry
    localparam int HDR_BITS = 56;
    localparam logic [11:0] SYNC_WORD = 12'hFFF;
    localparam logic [12:0] HDR_LEN = 13'd7;
    localparam logic [2:0] HDR_LAST_POS = 3'd6;

    // Result field widths
    localparam int OUT_COUNT_BITS = 20;
    localparam int OUT_OFFSET_BITS = 32;
    localparam int TARGET_BITS = 20;

    // Register map (word index)
    localparam logic REG_TARGET_FRAME = 1'b0;

    typedef enum logic [1:0] {
        KIND_HEADER   = 2'd0,
        KIND_SYNC_ERR = 2'd1,
        KIND_LEN_ERR  = 2'd2,
        KIND_SUMMARY  = 2'd3
    } kind_t;

    // One result record as it moves from front end to back end
    typedef struct packed {
        kind_t                        kind;
        logic [HDR_BITS-1:0]          hdr;
        logic [OUT_COUNT_BITS-1:0]    count;
        logic [OUT_OFFSET_BITS-1:0]   offset;
        logic                         hit;
    } evt_t;

    // Header field extraction
    function automatic logic [11:0] hdr_sync(input logic [HDR_BITS-1:0] h);
        return h[55:44];
    endfunction

    function automatic logic [12:0] hdr_flen(input logic [HDR_BITS-1:0] h);
        return h[25:13];
    endfunction

endpackage

// File: rtl/adts_frame_scanner_unit.sv
// ADTS frame scanner. Takes one stream byte per clock on the input channel and
// gathers 7-byte ADTS headers, checks the 0xFFF sync word, skips each frame's
// remaining frame_size - 7 bytes and keeps a frame count and byte offset.
// Each complete header gives one result (kind 0 parsed, 1 sync error, 2 length
// error); after an error, bytes are dropped until the end marker, which gives
// a kind 3 summary and clears the stream state (target_frame is kept).
// Sustained rate is one byte per clock; a result enters the queue with the
// byte that completes it and moves on to the output register. A two-entry queue
// sits between the byte parser and the output register, so input bytes keep
// flowing while results wait to be taken; the input stalls only while the
// output register and both queue entries are occupied.
// target_frame is at APB byte address 0.
module adts_frame_scanner_unit
    import adts_fs_pkg::*;
#(
    parameter int COUNT_BITS  = 20,
    parameter int OFFSET_BITS = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // APB configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // byte stream
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 data_byte,
    input  logic                       end_marker,
    // results
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 kind,
    output logic                       mpeg_version,
    output logic [1:0]                 profile,
    output logic [3:0]                 rate_index,
    output logic [2:0]                 channel_config,
    output logic                       crc_absent,
    output logic [12:0]                frame_size,
    output logic [10:0]                buffer_fullness,
    output logic [1:0]                 raw_blocks,
    output logic [OUT_COUNT_BITS-1:0]  frame_count,
    output logic [OUT_OFFSET_BITS-1:0] end_offset,
    output logic                       target_hit
);

    logic [TARGET_BITS-1:0] target_reg;
    logic                   cfg_wr;
    logic                   q_full;
    logic                   q_push;
    logic                   q_pop;
    logic                   q_not_empty;
    evt_t                   push_evt;
    evt_t                   pop_evt;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TARGET_FRAME);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_wr)
        begin
            target_reg <= pwdata[TARGET_BITS-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_TARGET_FRAME)
        begin
            prdata = {{(32-TARGET_BITS){1'b0}}, target_reg};
        end
    end

    adts_fs_front #(
        .COUNT_BITS  (COUNT_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .end_marker   (end_marker),
        .target_frame (target_reg),
        .q_full       (q_full),
        .push         (q_push),
        .push_evt     (push_evt)
    );

    adts_fs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_evt  (push_evt),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_evt   (pop_evt)
    );

    adts_fs_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_not_empty     (q_not_empty),
        .q_evt           (pop_evt),
        .pop             (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .mpeg_version    (mpeg_version),
        .profile         (profile),
        .rate_index      (rate_index),
        .channel_config  (channel_config),
        .crc_absent      (crc_absent),
        .frame_size      (frame_size),
        .buffer_fullness (buffer_fullness),
        .raw_blocks      (raw_blocks),
        .frame_count     (frame_count),
        .end_offset      (end_offset),
        .target_hit      (target_hit)
    );

endmodule

// File: rtl/adts_fs_queue.sv
module adts_fs_queue
    import adts_fs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  evt_t push_evt,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output evt_t pop_evt
);

    evt_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_evt   = slot_reg[rd_ptr_reg];

    // Occupancy update
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_evt;
        end
    end

endmodule

// File: rtl/adts_fs_front.sv
module adts_fs_front
    import adts_fs_pkg::*;
#(
    parameter int COUNT_BITS  = 20,
    parameter int OFFSET_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             data_byte,
    input  logic                   end_marker,
    input  logic [TARGET_BITS-1:0] target_frame,
    input  logic                   q_full,
    output logic                   push,
    output evt_t                   push_evt
);

    localparam int CW = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;
    localparam int TW = (CW > TARGET_BITS) ? CW : TARGET_BITS;
    localparam int OW = (OFFSET_BITS > OUT_OFFSET_BITS) ? OFFSET_BITS : OUT_OFFSET_BITS;

    logic [47:0]            hdr_reg;
    logic [47:0]            hdr_next;
    logic [2:0]             pos_reg;
    logic [2:0]             pos_next;
    logic [12:0]            skip_reg;
    logic [12:0]            skip_next;
    logic [COUNT_BITS-1:0]  frames_reg;
    logic [COUNT_BITS-1:0]  frames_next;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [OFFSET_BITS-1:0] offset_next;
    logic                   halted_reg;
    logic                   halted_next;

    logic                   accept;
    logic [HDR_BITS-1:0]    full_hdr;
    logic [12:0]            flen;
    logic [COUNT_BITS-1:0]  frames_inc;
    logic [OFFSET_BITS-1:0] offset_add;
    logic [CW-1:0]          cnt_old_ext;
    logic [CW-1:0]          cnt_new_ext;
    logic [OW-1:0]          off_old_ext;
    logic [OW-1:0]          off_new_ext;
    logic                   hit_new;
    kind_t                  hdr_kind;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Header word with the current byte shifted in
    assign full_hdr   = {hdr_reg, data_byte};
    assign flen       = hdr_flen(full_hdr);
    assign frames_inc = frames_reg + {{(COUNT_BITS-1){1'b0}}, 1'b1};
    assign offset_add = offset_reg + {{(OFFSET_BITS-13){1'b0}}, flen};

    // Counters as seen on the result fields
    assign cnt_old_ext = CW'(frames_reg);
    assign cnt_new_ext = CW'(frames_inc);
    assign off_old_ext = OW'(offset_reg);
    assign off_new_ext = OW'(offset_add);
    assign hit_new     = (target_frame != '0) && (TW'(frames_inc) == TW'(target_frame));

    // Header classification
    always_comb
    begin
        if (hdr_sync(full_hdr) != SYNC_WORD)
        begin
            hdr_kind = KIND_SYNC_ERR;
        end
        else if (flen < HDR_LEN)
        begin
            hdr_kind = KIND_LEN_ERR;
        end
        else
        begin
            hdr_kind = KIND_HEADER;
        end
    end

    // Per-byte state update and result record
    always_comb
    begin
        hdr_next    = hdr_reg;
        pos_next    = pos_reg;
        skip_next   = skip_reg;
        frames_next = frames_reg;
        offset_next = offset_reg;
        halted_next = halted_reg;
        push        = 1'b0;
        push_evt    = '0;

        if (accept)
        begin
            if (end_marker)
            begin
                push            = 1'b1;
                push_evt.kind   = KIND_SUMMARY;
                push_evt.count  = cnt_old_ext[OUT_COUNT_BITS-1:0];
                push_evt.offset = off_old_ext[OUT_OFFSET_BITS-1:0];
                hdr_next        = '0;
                pos_next        = '0;
                skip_next       = '0;
                frames_next     = '0;
                offset_next     = '0;
                halted_next     = 1'b0;
            end
            else if (halted_reg)
            begin
                // dropped until end of stream
            end
            else if (skip_reg != '0)
            begin
                skip_next = skip_reg - 13'd1;
            end
            else
            begin
                hdr_next = full_hdr[47:0];
                if (pos_reg != HDR_LAST_POS)
                begin
                    pos_next = pos_reg + 3'd1;
                end
                else
                begin
                    pos_next      = '0;
                    push          = 1'b1;
                    push_evt.kind = hdr_kind;
                    push_evt.hdr  = full_hdr;
                    if (hdr_kind == KIND_HEADER)
                    begin
                        frames_next     = frames_inc;
                        offset_next     = offset_add;
                        skip_next       = flen - HDR_LEN;
                        push_evt.count  = cnt_new_ext[OUT_COUNT_BITS-1:0];
                        push_evt.offset = off_new_ext[OUT_OFFSET_BITS-1:0];
                        push_evt.hit    = hit_new;
                    end
                    else
                    begin
                        halted_next     = 1'b1;
                        push_evt.count  = cnt_old_ext[OUT_COUNT_BITS-1:0];
                        push_evt.offset = off_old_ext[OUT_OFFSET_BITS-1:0];
                    end
                end
            end
        end
    end

    // Stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg    <= '0;
            pos_reg    <= '0;
            skip_reg   <= '0;
            frames_reg <= '0;
            offset_reg <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            hdr_reg    <= hdr_next;
            pos_reg    <= pos_next;
            skip_reg   <= skip_next;
            frames_reg <= frames_next;
            offset_reg <= offset_next;
            halted_reg <= halted_next;
        end
    end

endmodule

// File: rtl/adts_fs_back.sv
module adts_fs_back
    import adts_fs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_not_empty,
    input  evt_t                       q_evt,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 kind,
    output logic                       mpeg_version,
    output logic [1:0]                 profile,
    output logic [3:0]                 rate_index,
    output logic [2:0]                 channel_config,
    output logic                       crc_absent,
    output logic [12:0]                frame_size,
    output logic [10:0]                buffer_fullness,
    output logic [1:0]                 raw_blocks,
    output logic [OUT_COUNT_BITS-1:0]  frame_count,
    output logic [OUT_OFFSET_BITS-1:0] end_offset,
    output logic                       target_hit
);

    evt_t out_reg;
    logic out_valid_reg;
    logic load;

    // Output register refills whenever it is empty or being drained
    assign load = !out_valid_reg || out_ready;
    assign pop  = load && q_not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= q_not_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= q_evt;
        end
    end

    // Unpack header fields
    assign out_valid       = out_valid_reg;
    assign kind            = out_reg.kind;
    assign mpeg_version    = out_reg.hdr[43];
    assign profile         = out_reg.hdr[39:38];
    assign rate_index      = out_reg.hdr[37:34];
    assign channel_config  = out_reg.hdr[32:30];
    assign crc_absent      = out_reg.hdr[40];
    assign frame_size      = hdr_flen(out_reg.hdr);
    assign buffer_fullness = out_reg.hdr[12:2];
    assign raw_blocks      = out_reg.hdr[1:0];
    assign frame_count     = out_reg.count;
    assign end_offset      = out_reg.offset;
    assign target_hit      = out_reg.hit;

endmodule
